/* src/lzes_pkg.sv */
// lzes_pkg: shared types, register codes and saturation helpers
// for the lorenz euler stepper; no dependencies
package lzes_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 16;
    localparam int INDEX_W = 3;
    localparam int PROD_W  = 2 * WORD_W;

    localparam logic [INDEX_W-1:0] REG_SIGMA = 3'd0;
    localparam logic [INDEX_W-1:0] REG_RHO   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_BETA  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_DT    = 3'd3;
    localparam logic [INDEX_W-1:0] REG_LIMIT = 3'd4;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd50500;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t value;
        logic  clamp;
    } sat_res_t;

    function automatic sat_res_t sat_wide(input logic signed [PROD_W-1:0] v);
        sat_res_t r;
        if (v > $signed({{(PROD_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}}))
        begin
            r.value = {1'b0, {(WORD_W-1){1'b1}}};
            r.clamp = 1'b1;
        end
        else if (v < $signed({{(PROD_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}}))
        begin
            r.value = {1'b1, {(WORD_W-1){1'b0}}};
            r.clamp = 1'b1;
        end
        else
        begin
            r.value = v[WORD_W-1:0];
            r.clamp = 1'b0;
        end
        return r;
    endfunction

    function automatic sat_res_t sat_sum(input logic signed [WORD_W:0] v);
        sat_res_t r;
        if (v[WORD_W] != v[WORD_W-1])
        begin
            r.value = {v[WORD_W], {(WORD_W-1){~v[WORD_W]}}};
            r.clamp = 1'b1;
        end
        else
        begin
            r.value = v[WORD_W-1:0];
            r.clamp = 1'b0;
        end
        return r;
    endfunction

endpackage

/* src/lzes_ifs.sv */
// lzes_ifs: request, result and register-write channels of the stepper
// depends on lzes_pkg
interface lzes_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface lzes_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [lzes_pkg::WORD_W-1:0] x_value;
    logic signed [lzes_pkg::WORD_W-1:0] y_value;
    logic signed [lzes_pkg::WORD_W-1:0] z_value;
    logic [lzes_pkg::COUNT_W-1:0]   steps_done;
    logic                           limit_reached;
    logic                           saturated;

    modport source (output valid, output x_value, output y_value, output z_value,
                    output steps_done, output limit_reached, output saturated,
                    input ready);
    modport sink (input valid, input x_value, input y_value, input z_value,
                  input steps_done, input limit_reached, input saturated,
                  output ready);
endinterface

interface lzes_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lzes_pkg::INDEX_W-1:0]  index;
    logic [lzes_pkg::WORD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/lorenz_euler_stepper.sv */
// lorenz_euler_stepper: one forward-euler step of the lorenz system per request below the step limit;
// restart requests reload the origin; depends on lzes_pkg, lzes_ifs and lzes_fmul
//
//   channel   dir   contents
//   req_in    in    restart
//   res_out   out   x_value y_value z_value steps_done limit_reached saturated
//   cfg       in    index data (sigma, rho, beta, dt, step limit)
//
// a step request latches differences, runs the phases sigma to last through the
// single shared multiplier (seven products, issue and writeback overlapped) and
// loads the result register in done; restart and held requests skip the phases.
// reset loads default gains, origin (2,1,1) and a zero count.
// a stalled result holds the block in its final cycle; the next request is
// taken while the previous result still waits.
module lorenz_euler_stepper #(
    parameter int FRAC_BITS = 24
) (
    input  logic       clk,
    input  logic       rst_n,
    lzes_in_if.sink    req_in,
    lzes_out_if.source res_out,
    lzes_cfg_if.sink   cfg
);
    import lzes_pkg::*;

    localparam logic signed [PROD_W-1:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam sat_res_t SIGMA_R = sat_wide(64'sd10 * ONE);
    localparam sat_res_t RHO_R   = sat_wide(64'sd28 * ONE);
    localparam sat_res_t BETA_R  = sat_wide((64'sd16 * ONE + 64'sd3) / 64'sd6);
    localparam sat_res_t DT_R    = sat_wide((64'sd6 * ONE + 64'sd1000) / 64'sd2000);
    localparam sat_res_t ORGX_R  = sat_wide(64'sd2 * ONE);
    localparam sat_res_t ORG1_R  = sat_wide(ONE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [2:0] PH_SIGMA = 3'd0;
    localparam logic [2:0] PH_XRHO  = 3'd1;
    localparam logic [2:0] PH_XY    = 3'd2;
    localparam logic [2:0] PH_BETA  = 3'd3;
    localparam logic [2:0] PH_DX    = 3'd4;
    localparam logic [2:0] PH_DY    = 3'd5;
    localparam logic [2:0] PH_DZ    = 3'd6;
    localparam logic [2:0] PH_LAST  = 3'd7;

    word_t              sigma_reg, rho_reg, beta_reg, dt_reg;
    logic [COUNT_W-1:0] limit_reg;

    word_t              x_reg, y_reg, z_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [1:0] state_reg;
    logic [2:0] phase_reg;
    word_t      d1_reg, d2_reg, ta_reg, tb_reg, tc_reg;
    logic       clamp_reg, held_reg;

    logic               out_valid_reg;
    word_t              out_x_reg, out_y_reg, out_z_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_held_reg, out_sat_reg;

    word_t    mul_a, mul_b;
    sat_res_t mul_res;
    word_t    add_a, add_b;
    logic     add_sub;
    sat_res_t add_res;
    sat_res_t d1_res, d2_res;
    logic     req_fire, out_free;

    lzes_fmul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_fmul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .res  (mul_res)
    );

    assign req_fire = req_in.valid && req_in.ready;
    assign out_free = !out_valid_reg || res_out.ready;

    assign req_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    assign d1_res = sat_sum({y_reg[WORD_W-1], y_reg} - {x_reg[WORD_W-1], x_reg});
    assign d2_res = sat_sum({rho_reg[WORD_W-1], rho_reg} - {z_reg[WORD_W-1], z_reg});

    // operand select for the shared multiplier
    always_comb
    begin
        case (phase_reg)
            PH_SIGMA:
            begin
                mul_a = sigma_reg;
                mul_b = d1_reg;
            end
            PH_XRHO:
            begin
                mul_a = x_reg;
                mul_b = d2_reg;
            end
            PH_XY:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            PH_BETA:
            begin
                mul_a = beta_reg;
                mul_b = z_reg;
            end
            PH_DX:
            begin
                mul_a = ta_reg;
                mul_b = dt_reg;
            end
            PH_DY:
            begin
                mul_a = tb_reg;
                mul_b = dt_reg;
            end
            PH_DZ:
            begin
                mul_a = tc_reg;
                mul_b = dt_reg;
            end
            default:
            begin
                mul_a = tc_reg;
                mul_b = dt_reg;
            end
        endcase
    end

    // shared adder on the writeback of the previous product
    always_comb
    begin
        add_a   = mul_res.value;
        add_b   = y_reg;
        add_sub = 1'b0;
        case (phase_reg)
            PH_XY:
            begin
                add_a   = mul_res.value;
                add_b   = y_reg;
                add_sub = 1'b1;
            end
            PH_DX:
            begin
                add_a   = tc_reg;
                add_b   = mul_res.value;
                add_sub = 1'b1;
            end
            PH_DY:
            begin
                add_a = x_reg;
                add_b = mul_res.value;
            end
            PH_DZ:
            begin
                add_a = y_reg;
                add_b = mul_res.value;
            end
            PH_LAST:
            begin
                add_a = z_reg;
                add_b = mul_res.value;
            end
            default:
            begin
                add_a   = mul_res.value;
                add_b   = y_reg;
                add_sub = 1'b0;
            end
        endcase
        add_res = add_sub ? sat_sum({add_a[WORD_W-1], add_a} - {add_b[WORD_W-1], add_b})
                          : sat_sum({add_a[WORD_W-1], add_a} + {add_b[WORD_W-1], add_b});
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg <= SIGMA_R.value;
            rho_reg   <= RHO_R.value;
            beta_reg  <= BETA_R.value;
            dt_reg    <= DT_R.value;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SIGMA: sigma_reg <= cfg.data;
                REG_RHO:   rho_reg   <= cfg.data;
                REG_BETA:  beta_reg  <= cfg.data;
                REG_DT:    dt_reg    <= cfg.data;
                REG_LIMIT: limit_reg <= cfg.data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SIGMA;
            x_reg     <= ORGX_R.value;
            y_reg     <= ORG1_R.value;
            z_reg     <= ORG1_R.value;
            count_reg <= '0;
            clamp_reg <= 1'b0;
            held_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        phase_reg <= PH_SIGMA;
                        if (req_in.restart)
                        begin
                            x_reg     <= ORGX_R.value;
                            y_reg     <= ORG1_R.value;
                            z_reg     <= ORG1_R.value;
                            count_reg <= '0;
                            clamp_reg <= 1'b0;
                            held_reg  <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else if (count_reg >= limit_reg)
                        begin
                            clamp_reg <= 1'b0;
                            held_reg  <= 1'b1;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            clamp_reg <= d1_res.clamp | d2_res.clamp;
                            held_reg  <= 1'b0;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    phase_reg <= phase_reg + 3'd1;
                    case (phase_reg)
                        PH_XRHO:
                        begin
                            ta_reg    <= mul_res.value;
                            clamp_reg <= clamp_reg | mul_res.clamp;
                        end
                        PH_XY:
                        begin
                            tb_reg    <= add_res.value;
                            clamp_reg <= clamp_reg | mul_res.clamp | add_res.clamp;
                        end
                        PH_BETA:
                        begin
                            tc_reg    <= mul_res.value;
                            clamp_reg <= clamp_reg | mul_res.clamp;
                        end
                        PH_DX:
                        begin
                            tc_reg    <= add_res.value;
                            clamp_reg <= clamp_reg | mul_res.clamp | add_res.clamp;
                        end
                        PH_DY:
                        begin
                            x_reg     <= add_res.value;
                            clamp_reg <= clamp_reg | mul_res.clamp | add_res.clamp;
                        end
                        PH_DZ:
                        begin
                            y_reg     <= add_res.value;
                            clamp_reg <= clamp_reg | mul_res.clamp | add_res.clamp;
                        end
                        PH_LAST:
                        begin
                            z_reg     <= add_res.value;
                            clamp_reg <= clamp_reg | mul_res.clamp | add_res.clamp;
                            count_reg <= count_reg + 1'b1;
                            state_reg <= ST_DONE;
                        end
                        default: ;
                    endcase
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_fire)
        begin
            d1_reg <= d1_res.value;
            d2_reg <= d2_res.value;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_x_reg     <= x_reg;
            out_y_reg     <= y_reg;
            out_z_reg     <= z_reg;
            out_count_reg <= count_reg;
            out_held_reg  <= held_reg;
            out_sat_reg   <= clamp_reg;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.x_value       = out_x_reg;
    assign res_out.y_value       = out_y_reg;
    assign res_out.z_value       = out_z_reg;
    assign res_out.steps_done    = out_count_reg;
    assign res_out.limit_reached = out_held_reg;
    assign res_out.saturated     = out_sat_reg;

endmodule

/* src/lzes_fmul.sv */
// lzes_fmul: shared fixed-point multiplier, registered product then
// arithmetic shift and saturation; depends on lzes_pkg
module lzes_fmul #(
    parameter int FRAC_BITS = 24
) (
    input  logic               clk,
    input  lzes_pkg::word_t    op_a,
    input  lzes_pkg::word_t    op_b,
    output lzes_pkg::sat_res_t res
);
    import lzes_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] shifted;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign shifted = prod_reg >>> FRAC_BITS;
    assign res     = sat_wide(shifted);

endmodule

/* dv/lzes_checker.sv */
`timescale 1ns / 100ps
// lzes_checker: predicts every euler tick of the stepper and compares each result
// with the oldest prediction; watches the request, result and register channels
// depends on lzes_pkg and lzes_ifs
module lzes_checker #(
    parameter int FRAC_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    lzes_in_if   req_mon,
    lzes_out_if  res_mon,
    lzes_cfg_if  cfg_mon,
    output int   mismatches,
    output int   outstanding
);
    import lzes_pkg::*;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam longint ONE    = 64'sd1 <<< FRAC_BITS;

    typedef struct packed {
        word_t              x;
        word_t              y;
        word_t              z;
        logic [COUNT_W-1:0] steps;
        logic               held;
        logic               clamped;
    } tick_t;

    word_t              sigma_g;
    word_t              rho_g;
    word_t              beta_g;
    word_t              dt_g;
    logic [COUNT_W-1:0] limit_g;
    word_t              pos_x;
    word_t              pos_y;
    word_t              pos_z;
    logic [COUNT_W-1:0] count;
    bit                 tick_clamped;
    int                 fault_total;
    tick_t              head;
    tick_t              awaited_ticks[$];

    function automatic word_t clamp_word(input longint v);
        if (v > SAT_HI)
        begin
            tick_clamped = 1'b1;
            return word_t'(SAT_HI);
        end
        if (v < SAT_LO)
        begin
            tick_clamped = 1'b1;
            return word_t'(SAT_LO);
        end
        return word_t'(v);
    endfunction

    function automatic word_t fx_mul(input word_t a, input word_t b);
        return clamp_word((longint'(a) * longint'(b)) >>> FRAC_BITS);
    endfunction

    function automatic void load_origin();
        pos_x        = clamp_word(2 * ONE);
        pos_y        = clamp_word(ONE);
        pos_z        = clamp_word(ONE);
        count        = '0;
        tick_clamped = 1'b0;
    endfunction

    function automatic tick_t euler_tick(input logic restart);
        tick_t r;
        word_t x;
        word_t y;
        word_t z;
        word_t dxy;
        word_t drz;
        word_t dx;
        word_t dy;
        word_t dz;
        x            = pos_x;
        y            = pos_y;
        z            = pos_z;
        tick_clamped = 1'b0;
        r.held       = 1'b0;
        if (restart)
            load_origin();
        else if (count >= limit_g)
            r.held = 1'b1;
        else
        begin
            dxy   = clamp_word(longint'(y) - longint'(x));
            drz   = clamp_word(longint'(rho_g) - longint'(z));
            dx    = fx_mul(fx_mul(sigma_g, dxy), dt_g);
            dy    = fx_mul(clamp_word(longint'(fx_mul(x, drz)) - longint'(y)), dt_g);
            dz    = fx_mul(clamp_word(longint'(fx_mul(x, y))
                                      - longint'(fx_mul(beta_g, z))), dt_g);
            pos_x = clamp_word(longint'(x) + longint'(dx));
            pos_y = clamp_word(longint'(y) + longint'(dy));
            pos_z = clamp_word(longint'(z) + longint'(dz));
            count = count + 1'b1;
        end
        r.x       = pos_x;
        r.y       = pos_y;
        r.z       = pos_z;
        r.steps   = count;
        r.clamped = tick_clamped;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            fault_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_g     = clamp_word(10 * ONE);
            rho_g       = clamp_word(28 * ONE);
            beta_g      = clamp_word((16 * ONE + 3) / 6);
            dt_g        = clamp_word((6 * ONE + 1000) / 2000);
            limit_g     = LIMIT_RESET;
            load_origin();
            awaited_ticks.delete();
            fault_total = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.index)
                    REG_SIGMA: sigma_g = cfg_mon.data;
                    REG_RHO:   rho_g   = cfg_mon.data;
                    REG_BETA:  beta_g  = cfg_mon.data;
                    REG_DT:    dt_g    = cfg_mon.data;
                    REG_LIMIT: limit_g = cfg_mon.data[COUNT_W-1:0];
                    default:   ;
                endcase
            end
            if (res_mon.valid && res_mon.ready)
            begin
                if (awaited_ticks.size() == 0)
                begin
                    $display("%0t: result with no request waiting, expected none, got x %h",
                             $time, res_mon.x_value);
                    fault_total++;
                end
                else
                begin
                    head = awaited_ticks.pop_front();
                    check_field("x_value", head.x, res_mon.x_value);
                    check_field("y_value", head.y, res_mon.y_value);
                    check_field("z_value", head.z, res_mon.z_value);
                    check_field("steps_done", {{(WORD_W-COUNT_W){1'b0}}, head.steps},
                                {{(WORD_W-COUNT_W){1'b0}}, res_mon.steps_done});
                    check_field("limit_reached", {{(WORD_W-1){1'b0}}, head.held},
                                {{(WORD_W-1){1'b0}}, res_mon.limit_reached});
                    check_field("saturated", {{(WORD_W-1){1'b0}}, head.clamped},
                                {{(WORD_W-1){1'b0}}, res_mon.saturated});
                end
            end
            if (req_mon.valid && req_mon.ready)
                awaited_ticks = {awaited_ticks, euler_tick(req_mon.restart)};
            mismatches  <= fault_total;
            outstanding <= awaited_ticks.size();
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// testbench: drives tick requests and register writes into lorenz_euler_stepper
// under changing idle patterns and gives the verdict; depends on lzes_pkg,
// lzes_ifs, lzes_checker and the stepper itself
module testbench;
    import lzes_pkg::*;

    localparam int    FRAC         = 24;
    localparam int    HOLD_CYCLES  = 300;
    localparam int    STALL_LIMIT  = 4000;
    localparam int    DRAIN_CYCLES = 20;
    localparam int    PHASE_TICKS  = 107;
    localparam int    TX_IDLE[3]   = '{8, 67, 0};
    localparam int    RX_STALL[3]  = '{67, 8, 0};
    localparam logic  TICK_STEP    = 1'b0;
    localparam logic  TICK_RESTART = 1'b1;
    localparam word_t WORD_HI      = 32'sh7FFF_FFFF;
    localparam word_t WORD_LO      = 32'sh8000_0000;
    localparam word_t SIGMA_RESET  = 32'sd167772160;
    localparam word_t RHO_RESET    = 32'sd469762048;
    localparam word_t BETA_RESET   = 32'sd44739243;
    localparam word_t DT_RESET     = 32'sd50332;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    int   holds_asked  = 0;

    lzes_in_if  req_if ();
    lzes_out_if res_if ();
    lzes_cfg_if cfg_if ();

    lorenz_euler_stepper #(
        .FRAC_BITS (FRAC)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_in  (req_if),
        .res_out (res_if),
        .cfg     (cfg_if)
    );

    lzes_checker #(
        .FRAC_BITS (FRAC)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_if),
        .res_mon     (res_if),
        .cfg_mon     (cfg_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off whenever one is asked for
    initial
    begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served = holds_asked;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial
    begin
        int idle_run;
        idle_run = 0;
        while (idle_run < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("lorenz_euler_stepper test failed");
        $finish;
    end

    task automatic push_tick(input logic restart);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.restart <= restart;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] index, input word_t value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
    endtask

    task automatic load_gains(input word_t sigma, rho, beta, dt,
                              input logic [COUNT_W-1:0] limit);
        logic [INDEX_W-1:0] spare_index;
        spare_index = REG_LIMIT + INDEX_W'($urandom_range(1, 3));
        settle();
        write_reg(REG_SIGMA, sigma);
        write_reg(REG_RHO, rho);
        write_reg(REG_BETA, beta);
        write_reg(REG_DT, dt);
        write_reg(REG_LIMIT, {{(WORD_W-COUNT_W){1'b0}}, limit});
        // writes past the register list must leave everything alone
        write_reg(spare_index, $urandom);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic word_t pick_extreme();
        case ($urandom_range(0, 2))
            0:       return WORD_HI;
            1:       return WORD_LO;
            default: return '0;
        endcase
    endfunction

    task automatic random_setting(input int kind);
        word_t              sigma;
        word_t              rho;
        word_t              beta;
        word_t              dt;
        logic [COUNT_W-1:0] limit;
        case (kind)
            0:
            begin
                sigma = SIGMA_RESET;
                rho   = RHO_RESET;
                beta  = BETA_RESET;
                dt    = DT_RESET;
                limit = COUNT_W'($urandom_range(0, 120));
            end
            1:
            begin
                sigma = $urandom_range(0, 20 << FRAC);
                rho   = $urandom_range(0, 50 << FRAC);
                beta  = $urandom_range(0, 4 << FRAC);
                dt    = $urandom_range(0, 1 << (FRAC - 3));
                limit = COUNT_W'($urandom_range(0, 200));
            end
            2:
            begin
                sigma = pick_extreme();
                rho   = pick_extreme();
                beta  = pick_extreme();
                dt    = pick_extreme();
                limit = $urandom_range(0, 1) ? '1 : '0;
            end
            default:
            begin
                sigma = $urandom;
                rho   = $urandom;
                beta  = $urandom;
                dt    = $urandom;
                limit = COUNT_W'($urandom);
            end
        endcase
        load_gains(sigma, rho, beta, dt, limit);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.restart <= TICK_STEP;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= REG_SIGMA;
        cfg_if.data    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct  = TX_IDLE[0];
        rx_stall_pct = RX_STALL[0];

        // reset gains: steps, a restart, steps again
        repeat (3) push_tick(TICK_STEP);
        push_tick(TICK_RESTART);
        repeat (2) push_tick(TICK_STEP);

        // zero limit holds the state, even straight after a restart
        load_gains(SIGMA_RESET, RHO_RESET, BETA_RESET, DT_RESET, '0);
        push_tick(TICK_STEP);
        push_tick(TICK_RESTART);
        push_tick(TICK_STEP);

        // limit of three: the fourth step is held
        load_gains(SIGMA_RESET, RHO_RESET, BETA_RESET, DT_RESET, 16'd3);
        push_tick(TICK_RESTART);
        repeat (4) push_tick(TICK_STEP);

        // extreme gains drive differences, products and sums into saturation
        load_gains(WORD_HI, WORD_LO, WORD_LO, WORD_HI, '1);
        push_tick(TICK_RESTART);
        repeat (3) push_tick(TICK_STEP);
        load_gains(WORD_LO, WORD_HI, WORD_HI, WORD_LO, '1);
        repeat (3) push_tick(TICK_STEP);
        push_tick(TICK_RESTART);
        push_tick(TICK_STEP);

        for (int mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct  = TX_IDLE[mode];
            rx_stall_pct = RX_STALL[mode];
            for (int phase = 0; phase < 5; phase++)
            begin
                random_setting(phase < 4 ? phase : $urandom_range(0, 3));
                for (int n = 0; n < PHASE_TICKS; n++)
                begin
                    if (phase == 1 && n == 30)
                        holds_asked++;
                    push_tick((n == 0 || $urandom_range(0, 99) < 3) ? TICK_RESTART
                                                                   : TICK_STEP);
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("lorenz_euler_stepper test passed");
        else
            $display("lorenz_euler_stepper test failed");
        $finish;
    end

endmodule

/* sim.f */
src/lzes_pkg.sv
src/lzes_ifs.sv
src/lzes_fmul.sv
src/lorenz_euler_stepper.sv
dv/lzes_checker.sv
dv/testbench.sv
